[hdl/mf3_pkg.sv]
// Shared constants, types and the median sorting network table for the 3x3 median filter.
// No dependencies; every other file in hdl/ imports this package.
package mf3_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int PIXEL_BITS     = 8;
    localparam int WIN            = 3;
    localparam int HEIGHT_CAP     = 1024;

    localparam int COL_BITS   = $clog2(MAX_LINE_WIDTH);
    localparam int ROW_BITS   = 10;
    localparam int POS_BITS   = 10;
    localparam int CFG_BITS   = 11;
    localparam int LB_BITS    = 2 * PIXEL_BITS;

    localparam int S_TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = PIXEL_BITS + 2 * POS_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef logic [COL_BITS-1:0]   t_col;
    typedef logic [ROW_BITS-1:0]   t_row;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // line buffer write request
    typedef struct packed {
        logic               en;
        t_col               addr;
        logic [LB_BITS-1:0] data;
    } t_lb_wr;

    // 19 compare-exchange steps; after them entry 4 holds the median of nine
    localparam int MED_OPS = 19;
    typedef int t_op_tab [MED_OPS];
    localparam t_op_tab MED_A = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 2, 4, 2};
    localparam t_op_tab MED_B = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 4, 6, 4};

endpackage

[hdl/mf3_line_buf.sv]
// Dual line store: one memory holding {line two above, line one above} per column.
// Registered read with write-to-read forwarding; uses mf3_pkg.
module mf3_line_buf (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  mf3_pkg::t_col            i_rd_addr,
    input  mf3_pkg::t_lb_wr          i_wr,
    output logic [mf3_pkg::LB_BITS-1:0] o_rd_data
);
    import mf3_pkg::*;

    logic [LB_BITS-1:0] r_mem [MAX_LINE_WIDTH];
    logic [LB_BITS-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // same-column read and write happen when frame_start repeats at column 0
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rd <= i_wr.data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

[hdl/mf3_median9.sv]
// Combinational median of nine pixels by a fixed compare-exchange network.
// Uses the network table from mf3_pkg.
module mf3_median9 (
    input  mf3_pkg::t_pix i_win [9],
    output mf3_pkg::t_pix o_median
);
    import mf3_pkg::*;

    always_comb begin
        t_pix v [9];
        t_pix t;
        v = i_win;
        t = '0;
        for (int k = 0; k < MED_OPS; k++) begin
            if (v[MED_A[k]] > v[MED_B[k]]) begin
                t          = v[MED_A[k]];
                v[MED_A[k]] = v[MED_B[k]];
                v[MED_B[k]] = t;
            end
        end
        o_median = v[4];
    end

endmodule

[hdl/median_filter_3x3.sv]
// Top level of the 3x3 median filter: position tracking, window registers, result register.
// Depends on mf3_pkg, mf3_line_buf and mf3_median9.
//
//  channel | dir | handshake                          | payload
//  --------+-----+------------------------------------+-----------------------------------------
//  s_axis  | in  | i_s_axis_tvalid / o_s_axis_tready  | tdata: pixel; tuser: frame_start
//  m_axis  | out | o_m_axis_tvalid / i_m_axis_tready  | tdata: median, row, column; tlast
//  cfg     | in  | i_cfg_valid / o_cfg_ready          | i_cfg_index, i_cfg_data
//
// One item per clock sustained while the result register is not stalled. An item goes
// through two registers: the accept stage (line buffer read) and the result register;
// the result is written there when the item leaves the accept stage. Border items give no result but still
// pass through. Synchronous active-low reset clears position, window and
// valids; the line buffer needs no clearing. A stalled result register holds
// the pipe; the stage behind it keeps taking items that give no result.
module median_filter_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [mf3_pkg::S_TDATA_BITS-1:0] i_s_axis_tdata,  // [7:0] pixel
    input  logic                            i_s_axis_tuser,  // [0] frame_start
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [mf3_pkg::M_TDATA_BITS-1:0] o_m_axis_tdata,  // [7:0] median,
                                                              // [17:8] row, [27:18] col
    output logic                            o_m_axis_tlast,  // frame_last
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  mf3_pkg::t_reg_idx               i_cfg_index,
    input  logic [mf3_pkg::CFG_BITS-1:0]    i_cfg_data
);
    import mf3_pkg::*;

    localparam logic [CFG_BITS-1:0] CFG_WIN = CFG_BITS'(WIN);
    localparam logic [CFG_BITS-1:0] CFG_MAXW = CFG_BITS'(MAX_LINE_WIDTH);
    localparam logic [CFG_BITS-1:0] CFG_MAXH = CFG_BITS'(HEIGHT_CAP);

    // effective last column / last row after clamping
    t_col r_w_last;
    t_row r_h_last;

    // position of next item
    t_col r_col;
    t_row r_row;

    // accept stage
    logic r_s1_valid;
    logic r_s1_emit;
    logic r_s1_last;
    t_pix r_s1_pix;
    t_col r_s1_col;
    t_row r_s1_row;

    // window: two previous columns, three pixels each
    t_pix r_wc [6];

    // result register
    logic                   r_out_valid;
    t_pix                   r_out_med;
    logic [POS_BITS-1:0]    r_out_row;
    logic [POS_BITS-1:0]    r_out_col;
    logic                   r_out_last;

    logic   out_free, s1_adv, s_ready, accept;
    t_col   cur_col, n_col;
    t_row   cur_row, n_row;
    t_lb_wr lb_wr;
    logic [LB_BITS-1:0] lb_rd;
    t_pix   up, lo, median;
    t_pix   win [9];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= COL_BITS'(MAX_LINE_WIDTH - 1);
            r_h_last <= ROW_BITS'(HEIGHT_CAP - 1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    if (i_cfg_data < CFG_WIN) begin
                        r_w_last <= COL_BITS'(WIN - 1);
                    end else if (i_cfg_data > CFG_MAXW) begin
                        r_w_last <= COL_BITS'(MAX_LINE_WIDTH - 1);
                    end else begin
                        r_w_last <= COL_BITS'(i_cfg_data - 1'b1);
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    if (i_cfg_data < CFG_WIN) begin
                        r_h_last <= ROW_BITS'(WIN - 1);
                    end else if (i_cfg_data > CFG_MAXH) begin
                        r_h_last <= ROW_BITS'(HEIGHT_CAP - 1);
                    end else begin
                        r_h_last <= ROW_BITS'(i_cfg_data - 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // handshake: stage 1 retires when it has no result or the result slot is free
    always_comb begin
        out_free = !r_out_valid || i_m_axis_tready;
        s1_adv   = r_s1_valid && (!r_s1_emit || out_free);
        s_ready  = !r_s1_valid || s1_adv;
        accept   = i_s_axis_tvalid && s_ready;
    end

    assign o_s_axis_tready = s_ready;

    // position of the incoming item, frame_start restarts at the origin
    always_comb begin
        cur_col = i_s_axis_tuser ? '0 : r_col;
        cur_row = i_s_axis_tuser ? '0 : r_row;
        if (cur_col >= r_w_last) begin
            n_col = '0;
            n_row = (cur_row >= r_h_last) ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_ready) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= i_s_axis_tdata[PIXEL_BITS-1:0];
            r_s1_col  <= cur_col;
            r_s1_row  <= cur_row;
            r_s1_emit <= (cur_row >= ROW_BITS'(WIN - 1)) && (cur_col >= COL_BITS'(WIN - 1));
            r_s1_last <= (cur_row == r_h_last) && (cur_col == r_w_last);
        end
    end

    // line buffer: read at accept, write back when the item retires
    always_comb begin
        lb_wr.en   = s1_adv;
        lb_wr.addr = r_s1_col;
        lb_wr.data = {lo, r_s1_pix};
    end

    mf3_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (cur_col),
        .i_wr      (lb_wr),
        .o_rd_data (lb_rd)
    );

    assign up = lb_rd[LB_BITS-1:PIXEL_BITS];
    assign lo = lb_rd[PIXEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_wc[i] <= '0;
            end
        end else if (s1_adv) begin
            r_wc[0] <= r_wc[3];
            r_wc[1] <= r_wc[4];
            r_wc[2] <= r_wc[5];
            r_wc[3] <= up;
            r_wc[4] <= lo;
            r_wc[5] <= r_s1_pix;
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            win[i] = r_wc[i];
        end
        win[6] = up;
        win[7] = lo;
        win[8] = r_s1_pix;
    end

    mf3_median9 u_median9 (
        .i_win    (win),
        .o_median (median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_out_med  <= median;
            r_out_row  <= POS_BITS'(r_s1_row - 1'b1);
            r_out_col  <= POS_BITS'(r_s1_col - 1'b1);
            r_out_last <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = M_TDATA_BITS'({r_out_col, r_out_row, r_out_med});

endmodule

[tb/tb.sv]
// Self-checking testbench for median_filter_3x3: directed frames, size extremes and random frames.
// Depends on mf3_pkg and the RTL in hdl/; it predicts every median with its own window model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT    = 2000;  // cycles without any handshake before giving up
    localparam int RANDOM_ITEMS  = 300;
    localparam int MAX_REPORTS   = 40;
    localparam int WIDE_ITEMS    = 64;
    localparam int TALL_ROWS     = 40;

    // One expected result item, split into the fields carried on m_axis.
    typedef struct {
        logic [PIXEL_BITS-1:0] median;
        logic [POS_BITS-1:0]   row;
        logic [POS_BITS-1:0]   col;
        logic                  last;
    } t_median_res;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [S_TDATA_BITS-1:0]   i_s_axis_tdata;
    logic                      i_s_axis_tuser;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [M_TDATA_BITS-1:0]   o_m_axis_tdata;
    logic                      o_m_axis_tlast;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    t_reg_idx                  i_cfg_index;
    logic [CFG_BITS-1:0]       i_cfg_data;

    // Window model: two line stores, six window pixels, position, registers.
    logic [PIXEL_BITS-1:0] upper_line [MAX_LINE_WIDTH];
    logic [PIXEL_BITS-1:0] lower_line [MAX_LINE_WIDTH];
    logic [PIXEL_BITS-1:0] win_cols [6];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [CFG_BITS-1:0]   width_reg;
    logic [CFG_BITS-1:0]   height_reg;
    // Set when the line got longer: the next item must start a frame so the
    // rows above are rewritten before any window reads them.
    bit                    width_grew;

    t_median_res           medians_due [$];
    int                    errors;
    int                    items_sent;
    int unsigned           idle_cycles;
    bit                    src_gaps_on;
    bit                    sink_stalls_on;

    median_filter_3x3 u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] pixel
        .i_s_axis_tuser  (i_s_axis_tuser),   // [0] frame_start
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] median, [17:8] row, [27:18] column
        .o_m_axis_tlast  (o_m_axis_tlast),   // [0] frame_last
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_dim(logic [CFG_BITS-1:0] v, int unsigned hi);
        if (v < WIN) return WIN;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // Fifth smallest: the value with at most four entries below it and at
    // least five at or below it.
    function automatic logic [PIXEL_BITS-1:0] median_of_nine(logic [PIXEL_BITS-1:0] v [9]);
        int below;
        int not_above;
        for (int i = 0; i < 9; i++) begin
            below = 0;
            not_above = 0;
            for (int k = 0; k < 9; k++) begin
                if (v[k] < v[i]) below++;
                if (v[k] <= v[i]) not_above++;
            end
            if (below <= 4 && not_above >= 5) return v[i];
        end
        return '0;
    endfunction

    function automatic void predict_pixel(logic [PIXEL_BITS-1:0] pix, logic frame_start);
        int unsigned           w;
        int unsigned           h;
        int unsigned           col;
        int unsigned           row;
        logic [PIXEL_BITS-1:0] up;
        logic [PIXEL_BITS-1:0] lo;
        logic [PIXEL_BITS-1:0] nbhd [9];
        t_median_res           res;
        w = clamp_dim(width_reg, MAX_LINE_WIDTH);
        h = clamp_dim(height_reg, HEIGHT_CAP);
        if (frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        up  = upper_line[col];
        lo  = lower_line[col];
        // bottom-right corner of a full window: one result
        if (row >= 2 && col >= 2) begin
            for (int i = 0; i < 6; i++) nbhd[i] = win_cols[i];
            nbhd[6] = up;
            nbhd[7] = lo;
            nbhd[8] = pix;
            res.median = median_of_nine(nbhd);
            res.row    = POS_BITS'(row - 1);
            res.col    = POS_BITS'(col - 1);
            res.last   = (row == h - 1) && (col == w - 1);
            medians_due.push_back(res);
        end
        upper_line[col] = lo;
        lower_line[col] = pix;
        for (int i = 0; i < 3; i++) win_cols[i] = win_cols[i + 3];
        win_cols[3] = up;
        win_cols[4] = lo;
        win_cols[5] = pix;
        // a column past a shrunk line end wraps like the last one
        if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // mode 1 draws from a few values so that windows are full of ties
    function automatic logic [PIXEL_BITS-1:0] pick_pixel(int mode);
        if (mode == 0) return PIXEL_BITS'($urandom);
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return PIXEL_BITS'(8'h80);
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_dim();
        if ($urandom_range(9) == 0) return CFG_BITS'($urandom_range(WIN - 1, 0));
        return CFG_BITS'($urandom_range(8, WIN));
    endfunction

    // Called at a falling edge; returns at a falling edge. tvalid stays high
    // when the next item follows without a gap.
    task automatic send_pixel(logic [PIXEL_BITS-1:0] pix, logic frame_start);
        logic fs;
        int   gap;
        fs = frame_start | width_grew;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_TDATA_BITS'(pix);
        i_s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_pixel(pix, fs);
        if (fs) width_grew = 1'b0;
        items_sent++;
        @(negedge i_clk);
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Sender holds off until every expected result is out, then lets the
    // pipe settle in case the last items gave no result.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (medians_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_BITS-1:0] val);
        int unsigned old_w;
        wait_drained();
        old_w = clamp_dim(width_reg, MAX_LINE_WIDTH);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = val;
            if (clamp_dim(val, MAX_LINE_WIDTH) > old_w) width_grew = 1'b1;
        end else begin
            height_reg = val;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(int n, logic restart, int mode);
        for (int i = 0; i < n; i++) send_pixel(pick_pixel(mode), (i == 0) && restart);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest frames with extreme pixels; the second frame follows the
    // first without frame_start (row wraps at frame end); the third uses
    // sizes below the minimum, which clamp to 3x3.
    task automatic test_small_frames();
        logic [PIXEL_BITS-1:0] split_px [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128,
                                                8'd255, 8'd0, 8'd255, 8'd0};
        logic [PIXEL_BITS-1:0] low_px [9]   = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd255,
                                                8'd0, 8'd0, 8'd0, 8'd1};
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(3));
        for (int i = 0; i < 9; i++) send_pixel(split_px[i], i == 0);
        for (int i = 0; i < 9; i++) send_pixel(low_px[i], 1'b0);
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(2));
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(2));
        send_frame(9, 1'b1, 1);
    endtask

    // Line shrinks while the position is past the new end, then the frame
    // gets shorter while its row is already past the new last row.
    task automatic test_resize_mid_frame();
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(6));
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(6));
        send_frame(2 * 6 + 5, 1'b1, 0);   // rows 0-1, then row 2 up to column 4
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(3));
        send_frame(1 + 3, 1'b0, 0);       // column 5 wraps; row 3 at width 3
        write_reg(REG_IMAGE_HEIGHT, CFG_BITS'(3));
        send_frame(3 + 9, 1'b0, 0);       // row 4 wraps to 0, then a full frame
    endtask

    // Widest line: width above the range clamps to 1024, height 0 to 3;
    // only the start of the first line, which gives no result.
    task automatic test_wide_lines();
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, '0);
        send_frame(WIDE_ITEMS, 1'b1, 0);
    endtask

    // Top of the tallest frame at full rate: width 1 clamps to 3, height to
    // 1024, so the rows keep counting up without a wrap.
    task automatic test_tall_frame();
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        write_reg(REG_IMAGE_WIDTH, CFG_BITS'(1));
        write_reg(REG_IMAGE_HEIGHT, '1);
        send_frame(WIN * TALL_ROWS, 1'b1, 1);
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Mostly whole frames of random size and content; some are cut short,
    // some run on without frame_start, some change height midway.
    task automatic test_random_frames();
        int   start_count;
        int   r;
        int   n;
        int   split;
        int   mode;
        logic restart;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 40 || items_sent == start_count) begin
                write_reg(REG_IMAGE_WIDTH, pick_dim());
                write_reg(REG_IMAGE_HEIGHT, pick_dim());
            end else if (r < 50) begin
                wait_drained();
            end
            if ($urandom_range(7) == 0) begin
                src_gaps_on = $urandom_range(1);
                sink_stalls_on = $urandom_range(1);
            end
            n = clamp_dim(width_reg, MAX_LINE_WIDTH) * clamp_dim(height_reg, HEIGHT_CAP);
            split = -1;
            restart = 1'b1;
            mode = $urandom_range(1);
            r = $urandom_range(99);
            if (r < 15) n = $urandom_range(n - 1, 1);
            else if (r < 25) restart = 1'b0;
            else if (r < 32) split = $urandom_range(n - 1, 1);
            for (int i = 0; i < n; i++) begin
                if (i == split) write_reg(REG_IMAGE_HEIGHT, pick_dim());
                send_pixel(pick_pixel(mode), (i == 0) && restart);
            end
        end
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_median_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (medians_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: result item with none expected: expected nothing, got %h/%b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                want = medians_due.pop_front();
                check_field("median", 32'(want.median), 32'(o_m_axis_tdata[PIXEL_BITS-1:0]));
                check_field("centre_row", 32'(want.row),
                            32'(o_m_axis_tdata[PIXEL_BITS +: POS_BITS]));
                check_field("centre_column", 32'(want.col),
                            32'(o_m_axis_tdata[PIXEL_BITS + POS_BITS +: POS_BITS]));
                check_field("frame_last", 32'(want.last), 32'(o_m_axis_tlast));
                check_field("tdata padding", 0,
                            32'(o_m_axis_tdata >> M_FIELD_BITS));
            end
        end
    end

    // Receiver: ready in runs of random length, stalls mostly short, a few long.
    initial begin : sink_pacing
        int hold;
        hold = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!sink_stalls_on || $urandom_range(1) == 1) begin
                i_m_axis_tready <= 1'b1;
                hold = $urandom_range(12, 0);
            end else begin
                i_m_axis_tready <= 1'b0;
                hold = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2, 0);
            end
        end
    end

    // Watchdog: any accepted item on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_IMAGE_WIDTH;
        i_cfg_data      = '0;
        errors          = 0;
        items_sent      = 0;
        idle_cycles     = 0;
        src_gaps_on     = 1'b1;
        sink_stalls_on  = 1'b1;
        width_reg       = CFG_BITS'(MAX_LINE_WIDTH);
        height_reg      = CFG_BITS'(HEIGHT_CAP);
        width_grew      = 1'b1;
        col_pos         = 0;
        row_pos         = 0;
        foreach (win_cols[i]) win_cols[i] = '0;
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_small_frames();
        test_resize_mid_frame();
        test_wide_lines();
        test_tall_frame();
        test_random_frames();

        // everything out, then a further settling wait to catch stray results
        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
